### rtl/dds_pkg.sv
package dds_pkg;

    localparam int PHASE_BITS = 32;
    localparam int TABLE_BITS = 8;
    localparam int CODE_BITS  = 12;
    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int PROD_BITS  = 2 * CODE_BITS;

    localparam logic [CODE_BITS-1:0] CODE_MAX   = 12'd4095;
    localparam logic [CODE_BITS-1:0] ROUND_HALF = 12'd2047;

    // Configuration register indexes.
    localparam logic [1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [1:0] REG_LOW_CODE   = 2'd1;
    localparam logic [1:0] REG_HIGH_CODE  = 2'd2;

    typedef logic [CODE_BITS-1:0]  code_t;
    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef logic [TABLE_BITS-1:0] rom_addr_t;
    typedef logic [PROD_BITS-1:0]  prod_t;

    // One full sine period, offset binary, 0 .. 4095.
    localparam code_t SINE_ROM [TABLE_SIZE] = '{
        12'd2048, 12'd2098, 12'd2148, 12'd2198, 12'd2248, 12'd2298, 12'd2348, 12'd2398,
        12'd2447, 12'd2496, 12'd2545, 12'd2594, 12'd2642, 12'd2690, 12'd2737, 12'd2784,
        12'd2831, 12'd2877, 12'd2923, 12'd2968, 12'd3013, 12'd3057, 12'd3100, 12'd3143,
        12'd3185, 12'd3226, 12'd3267, 12'd3307, 12'd3346, 12'd3385, 12'd3423, 12'd3459,
        12'd3495, 12'd3530, 12'd3565, 12'd3598, 12'd3630, 12'd3662, 12'd3692, 12'd3722,
        12'd3750, 12'd3777, 12'd3804, 12'd3829, 12'd3853, 12'd3876, 12'd3898, 12'd3919,
        12'd3939, 12'd3958, 12'd3975, 12'd3992, 12'd4007, 12'd4021, 12'd4034, 12'd4045,
        12'd4056, 12'd4065, 12'd4073, 12'd4080, 12'd4085, 12'd4089, 12'd4093, 12'd4094,
        12'd4095, 12'd4094, 12'd4093, 12'd4089, 12'd4085, 12'd4080, 12'd4073, 12'd4065,
        12'd4056, 12'd4045, 12'd4034, 12'd4021, 12'd4007, 12'd3992, 12'd3975, 12'd3958,
        12'd3939, 12'd3919, 12'd3898, 12'd3876, 12'd3853, 12'd3829, 12'd3804, 12'd3777,
        12'd3750, 12'd3722, 12'd3692, 12'd3662, 12'd3630, 12'd3598, 12'd3565, 12'd3530,
        12'd3495, 12'd3459, 12'd3423, 12'd3385, 12'd3346, 12'd3307, 12'd3267, 12'd3226,
        12'd3185, 12'd3143, 12'd3100, 12'd3057, 12'd3013, 12'd2968, 12'd2923, 12'd2877,
        12'd2831, 12'd2784, 12'd2737, 12'd2690, 12'd2642, 12'd2594, 12'd2545, 12'd2496,
        12'd2447, 12'd2398, 12'd2348, 12'd2298, 12'd2248, 12'd2198, 12'd2148, 12'd2098,
        12'd2048, 12'd1997, 12'd1947, 12'd1897, 12'd1847, 12'd1797, 12'd1747, 12'd1697,
        12'd1648, 12'd1599, 12'd1550, 12'd1501, 12'd1453, 12'd1405, 12'd1358, 12'd1311,
        12'd1264, 12'd1218, 12'd1172, 12'd1127, 12'd1082, 12'd1038, 12'd995,  12'd952,
        12'd910,  12'd869,  12'd828,  12'd788,  12'd749,  12'd710,  12'd672,  12'd636,
        12'd600,  12'd565,  12'd530,  12'd497,  12'd465,  12'd433,  12'd403,  12'd373,
        12'd345,  12'd318,  12'd291,  12'd266,  12'd242,  12'd219,  12'd197,  12'd176,
        12'd156,  12'd137,  12'd120,  12'd103,  12'd88,   12'd74,   12'd61,   12'd50,
        12'd39,   12'd30,   12'd22,   12'd15,   12'd10,   12'd6,    12'd2,    12'd1,
        12'd0,    12'd1,    12'd2,    12'd6,    12'd10,   12'd15,   12'd22,   12'd30,
        12'd39,   12'd50,   12'd61,   12'd74,   12'd88,   12'd103,  12'd120,  12'd137,
        12'd156,  12'd176,  12'd197,  12'd219,  12'd242,  12'd266,  12'd291,  12'd318,
        12'd345,  12'd373,  12'd403,  12'd433,  12'd465,  12'd497,  12'd530,  12'd565,
        12'd600,  12'd636,  12'd672,  12'd710,  12'd749,  12'd788,  12'd828,  12'd869,
        12'd910,  12'd952,  12'd995,  12'd1038, 12'd1082, 12'd1127, 12'd1172, 12'd1218,
        12'd1264, 12'd1311, 12'd1358, 12'd1405, 12'd1453, 12'd1501, 12'd1550, 12'd1599,
        12'd1648, 12'd1697, 12'd1747, 12'd1797, 12'd1847, 12'd1897, 12'd1947, 12'd1997
    };

endpackage

### rtl/dds_sine_sample_generator.sv
// Sine NCO for a 12-bit DAC. Every input beat is one sample tick and yields
// exactly one output beat carrying a sample code between the configured low
// and high codes (swapped if given inverted). A restart beat zeroes the 32-bit
// phase accumulator before its own sample is taken. The block sustains one
// sample per clock while out_ready is high. The edge that accepts an input
// beat loads the sine ROM value and the band limits into the input register.
// The result register takes the span multiply and the divide by 4095 with
// offset from it when the second stage has room; out_valid is that stage's
// valid flag. The two stages are elastic. The input is taken whenever either
// stage has room or the result is being read, and it stalls only when both
// stages are full and out_ready is low. Configuration writes are always
// accepted and apply to input beats accepted from the next cycle on.
module dds_sine_sample_generator (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dds_pkg::code_t        sample,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import dds_pkg::*;

    phase_t    phase_step_reg;
    code_t     low_code_reg;
    code_t     high_code_reg;
    phase_t    phase_acc_reg;
    phase_t    phase_base;
    rom_addr_t rom_addr;

    logic      v1_reg, v2_reg;
    logic      adv1, adv2;
    logic      in_fire, cfg_fire;

    code_t     sine1_reg, lo1_reg, span1_reg;
    code_t     lo_next, span_next;
    prod_t     prod_next;

    logic [CODE_BITS-1:0] quo_est;
    logic [CODE_BITS:0]   rem_est;
    logic [CODE_BITS:0]   quo;
    logic [CODE_BITS:0]   code_sum;
    code_t                sample_next;
    code_t                sample_reg;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // Stall chain: a stage takes a new beat when it is empty or draining.
    assign adv2     = ~v2_reg | out_ready;
    assign adv1     = ~v1_reg | adv2;
    assign in_ready = adv1;
    assign in_fire  = in_valid & in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            low_code_reg   <= '0;
            high_code_reg  <= CODE_MAX;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_PHASE_STEP: phase_step_reg <= cfg_data;
                REG_LOW_CODE:   low_code_reg   <= cfg_data[CODE_BITS-1:0];
                REG_HIGH_CODE:  high_code_reg  <= cfg_data[CODE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    assign phase_base = restart ? '0 : phase_acc_reg;
    assign rom_addr   = phase_base[PHASE_BITS-1 -: TABLE_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_acc_reg <= phase_base + phase_step_reg;
        end
    end

    always_comb
    begin
        if (low_code_reg > high_code_reg)
        begin
            lo_next   = high_code_reg;
            span_next = low_code_reg - high_code_reg;
        end
        else
        begin
            lo_next   = low_code_reg;
            span_next = high_code_reg - low_code_reg;
        end
    end

    assign prod_next = PROD_BITS'(span1_reg) * PROD_BITS'(sine1_reg)
                     + PROD_BITS'(ROUND_HALF);

    // x / 4095: x >> 12 undershoots by at most one, so a single compare on
    // the remainder estimate fixes the quotient.
    assign quo_est  = prod_next[PROD_BITS-1:CODE_BITS];
    assign rem_est  = {1'b0, prod_next[CODE_BITS-1:0]} + {1'b0, quo_est};
    assign quo      = {1'b0, quo_est} + (CODE_BITS+1)'(rem_est >= {1'b0, CODE_MAX});
    assign code_sum = {1'b0, lo1_reg} + quo;
    assign sample_next = code_sum[CODE_BITS] ? CODE_MAX : code_sum[CODE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sine1_reg <= SINE_ROM[rom_addr];
            lo1_reg   <= lo_next;
            span1_reg <= span_next;
        end
        if (adv2 && v1_reg)
        begin
            sample_reg <= sample_next;
        end
    end

    assign out_valid = v2_reg;
    assign sample    = sample_reg;

`ifndef SYNTHESIS
    a_restart_acc: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && restart |=> phase_acc_reg == $past(phase_step_reg))
        else $error("accumulator not reloaded on restart");

    a_advance_acc: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !restart |=> phase_acc_reg == $past(phase_acc_reg + phase_step_reg))
        else $error("accumulator did not advance by the phase step");

    a_hold_acc: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(phase_acc_reg))
        else $error("accumulator moved without an input beat");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> v1_reg && v2_reg && !out_ready)
        else $error("input stalled while the pipeline has room");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample))
        else $error("pending result lost or changed");
`endif

endmodule

### verif/dds_sample_checker.sv
module dds_sample_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  logic           restart,
    input  logic           out_valid,
    input  logic           out_ready,
    input  dds_pkg::code_t sample,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    output int             mismatches,
    output int             samples_owed,
    output int             samples_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import dds_pkg::*;

    // Shadow copy of the oscillator state and its registers.
    phase_t step_reg;
    code_t  low_reg;
    code_t  high_reg;
    phase_t nco_phase;

    code_t expected_samples[$];

    // Maps a sine table value into the band between the two configured codes.
    function automatic code_t band_code(code_t sine);
        int unsigned lo;
        int unsigned hi;
        int unsigned code;
        lo = low_reg;
        hi = high_reg;
        if (lo > hi)
        begin
            lo = high_reg;
            hi = low_reg;
        end
        code = lo + ((hi - lo) * sine + ROUND_HALF) / CODE_MAX;
        if (code > CODE_MAX)
            code = CODE_MAX;
        return code_t'(code);
    endfunction

    task automatic predict_tick(logic clear);
        rom_addr_t addr;
        if (clear)
            nco_phase = '0;
        addr = nco_phase[PHASE_BITS-1 -: TABLE_BITS];
        nco_phase = nco_phase + step_reg;
        expected_samples.push_back(band_code(SINE_ROM[addr]));
    endtask

    task automatic check_sample(code_t actual);
        code_t want;
        samples_checked++;
        if (expected_samples.size() == 0)
        begin
            $error("sample: beat with nothing expected, expected none, actual %0d", actual);
            mismatches++;
        end
        else
        begin
            want = expected_samples.pop_front();
            if (actual !== want)
            begin
                $error("sample mismatch: expected %0d, actual %0d", want, actual);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  = '0;
            low_reg   = '0;
            high_reg  = CODE_MAX;
            nco_phase = '0;
            expected_samples.delete();
        end
        else
        begin
            // An input beat taken at the same edge as a register write still
            // sees the old setting.
            if (in_valid && in_ready)
                predict_tick(restart);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PHASE_STEP: step_reg = cfg_data;
                    REG_LOW_CODE:   low_reg  = cfg_data[CODE_BITS-1:0];
                    REG_HIGH_CODE:  high_reg = cfg_data[CODE_BITS-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                check_sample(sample);
        end
        samples_owed = expected_samples.size();
    end

    initial
    begin
        mismatches      = 0;
        samples_owed    = 0;
        samples_checked = 0;
    end

endmodule

### verif/tb_dds_sine_sample_generator.sv
module tb_dds_sine_sample_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import dds_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int RANDOM_TICKS = 1230;
    localparam int LONG_HOLD    = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        restart = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    code_t       sample;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int mismatches;
    int samples_owed;
    int samples_checked;

    int ticks_sent = 0;
    int restarts_sent = 0;
    int reg_writes = 0;
    int phases = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int idle_cycles;
    bit eager = 1'b0;

    always #2 clk = ~clk;

    dds_sine_sample_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dds_sample_checker sample_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .restart         (restart),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sample          (sample),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .samples_owed    (samples_owed),
        .samples_checked (samples_checked)
    );

    // All tasks below are entered and left at a falling edge.
    task automatic send_tick(logic clear);
        int gap;
        gap = eager ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= clear;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        ticks_sent++;
        if (clear)
            restarts_sent++;
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (samples_owed != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        reg_writes++;
    endtask

    // The unused index goes first with junk data; the block must ignore it.
    task automatic set_config(logic [31:0] step, logic [31:0] lo, logic [31:0] hi);
        write_reg(REG_SPARE, $urandom());
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_LOW_CODE, lo);
        write_reg(REG_HIGH_CODE, hi);
        cfg_valid <= 1'b0;
        phases++;
    endtask

    function automatic logic [31:0] pick_step();
        logic [31:0] val;
        case ($urandom_range(0, 5))
            0: val = 32'h0000_0000;
            1: val = 32'hFFFF_FFFF;
            2: val = 32'h1 << $urandom_range(0, 31);
            3: val = $urandom() >> $urandom_range(0, 31);
            default: val = $urandom();
        endcase
        return val;
    endfunction

    // Upper bits are sometimes dirty to check that the register keeps 12 bits.
    function automatic logic [31:0] pick_code();
        logic [31:0] val;
        case ($urandom_range(0, 4))
            0: val = 32'd0;
            1: val = 32'd4095;
            default: val = $urandom_range(0, 4095);
        endcase
        if ($urandom_range(0, 1) == 1)
            val = val | ($urandom() & 32'hFFFF_F000);
        return val;
    endfunction

    always
    begin
        @(negedge clk);
        if (rst_n)
        begin
            int stall;
            if (holds_served != hold_requests)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                holds_served++;
            end
            stall = eager ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [31:0] lo;
        logic [31:0] hi;
        int burst;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: zero step, full band.
        send_tick(1'b0);
        send_tick(1'b1);
        pause_until_drained();

        // Quarter-period step hits the table's midpoint, peak and trough.
        set_config(32'h4000_0000, 32'd0, 32'd4095);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        pause_until_drained();

        // Inverted band.
        set_config(32'h4000_0000, 32'd4000, 32'd100);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        pause_until_drained();

        // Equal codes, given with dirty upper bits.
        set_config(32'h0100_0000, 32'hFFFF_F4D2, 32'h0000_A4D2);
        repeat (3) send_tick(1'b0);
        pause_until_drained();

        // Largest step wraps the accumulator on every beat but the first after the restart.
        set_config(32'hFFFF_FFFF, 32'd4095, 32'd0);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        pause_until_drained();

        set_config(32'h8000_0000, 32'd0, 32'd0);
        repeat (2) send_tick(1'b0);
        pause_until_drained();

        while (ticks_sent < RANDOM_TICKS)
        begin
            lo = pick_code();
            hi = ($urandom_range(0, 7) == 0) ? lo : pick_code();
            set_config(pick_step(), lo, hi);
            eager = ($urandom_range(0, 3) == 0);
            // On the fifth random phase the sink holds off while the source
            // keeps streaming, so the pipeline fills and backs up the input.
            if (phases == 10)
            begin
                hold_requests++;
                eager = 1'b1;
            end
            burst = $urandom_range(20, 80);
            repeat (burst) send_tick($urandom_range(0, 15) == 0);
            pause_until_drained();
        end
        eager = 1'b0;

        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Sent %0d sample ticks (%0d restarts), checked %0d samples.",
                 ticks_sent, restarts_sent, samples_checked);
        $display("Programmed %0d band and step settings with %0d register beats.",
                 phases, reg_writes);
        if (mismatches == 0 && samples_owed == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
